[rtl/msb_first_bit_field_packer_hl_assert.svh]
// Assertion macros shared by the checker of the MSB-first bit-field packer.
// Every macro expects the signal clk, and MBFP_ASSERT also rst_n, in the scope where it is used.
`ifndef MSB_FIRST_BIT_FIELD_PACKER_HL_ASSERT_SVH
`define MSB_FIRST_BIT_FIELD_PACKER_HL_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define MBFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define MBFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/mbfp_pkg.sv]
// Package of the MSB-first bit-field packer: constants, codes and structs.
// No dependencies; imported by every module of the block.
`default_nettype none

package mbfp_pkg;

  localparam int FIELD_BITS  = 32;
  localparam int COUNT_BITS  = 16;
  localparam int BYTE_BITS   = 8;
  localparam int IDX_W       = $clog2(FIELD_BITS);
  localparam int NB_W        = $clog2(FIELD_BITS + 1);
  localparam int BF_W        = $clog2(BYTE_BITS + 1);
  localparam int POS_W       = $clog2(BYTE_BITS);
  localparam int LIMIT_W     = 16;
  localparam int CFG_W       = 16;
  localparam int CNT_IN_W    = 6;
  localparam int IN_TDATA_W  = ((CNT_IN_W + FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((BYTE_BITS + COUNT_BITS + 1 + 7) / 8) * 8;

  localparam logic [BYTE_BITS-1:0] PAD_RESET = 8'h2b;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_LENGTH_LIMIT = 2'd0;
  localparam cfg_idx_t CFG_PAD_CODE     = 2'd1;
  localparam cfg_idx_t CFG_FILL_BYTE    = 2'd2;

  typedef enum logic [1:0] {
    KIND_FIELD  = 2'd0,
    KIND_HL     = 2'd1,
    KIND_SPARE  = 2'd2,
    KIND_FINISH = 2'd3
  } kind_t;

  // Operation handed from the bit sequencer to the byte assembler each cycle.
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_BIT  = 2'd1,
    OP_FIN  = 2'd2,
    OP_END  = 2'd3
  } op_t;

  typedef struct packed {
    op_t  op;
    logic wr;
    logic hl;
    logic bit_val;
  } step_t;

  typedef struct packed {
    logic [LIMIT_W-1:0]   length_limit;
    logic [BYTE_BITS-1:0] pad_code;
    logic [BYTE_BITS-1:0] fill_byte;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0]  data_byte;
    logic                  byte_valid;
    logic                  last;
    logic [COUNT_BITS-1:0] byte_count;
    logic                  overflow;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } push_t;

endpackage

`default_nettype wire

[rtl/mbfp_bit_ser.sv]
// Bit sequencer: takes one item and presents its bits one per cycle while step_rdy is high, MSB first.
// Depends on mbfp_pkg.
`default_nettype none

module mbfp_bit_ser
  import mbfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            kind,
  input  logic [CNT_IN_W-1:0]   bit_count,
  input  logic [FIELD_BITS-1:0] value,
  output step_t                 step,
  input  logic                  step_rdy
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_END  = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  kind_t                 kind_r, kind_nxt;
  logic [FIELD_BITS-1:0] sh_r, sh_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [NB_W-1:0]       nb_r, nb_nxt;
  logic [NB_W-1:0]       nb_in;
  logic                  accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (int'(bit_count) > FIELD_BITS) begin
      nb_in = NB_W'(FIELD_BITS);
    end else begin
      nb_in = NB_W'(bit_count);
    end
  end

  always_comb begin
    step         = '0;
    step.op      = OP_NONE;
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    sh_nxt       = sh_r;
    idx_nxt      = idx_r;
    nb_nxt       = nb_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt  = kind_t'(kind);
          sh_nxt    = value;
          nb_nxt    = nb_in;
          state_nxt = S_RUN;
          unique case (kind_t'(kind))
            KIND_FIELD: idx_nxt = IDX_W'(FIELD_BITS - 1);
            KIND_SPARE: begin
              // An empty spare run has no bits, only the closing step.
              if (nb_in == '0) begin
                idx_nxt   = '0;
                state_nxt = S_END;
              end else begin
                idx_nxt = IDX_W'(nb_in - NB_W'(1));
              end
            end
            default: idx_nxt = '0;
          endcase
        end
      end
      S_RUN: begin
        step.hl = (kind_r == KIND_HL);
        if (kind_r == KIND_FINISH) begin
          step.op = OP_FIN;
        end else begin
          step.op = OP_BIT;
        end
        // A field walks all bit positions; only those below the count are written.
        if (kind_r == KIND_FIELD) begin
          step.wr      = (NB_W'(idx_r) < nb_r);
          step.bit_val = sh_r[FIELD_BITS-1];
        end else if (kind_r == KIND_HL) begin
          step.wr      = 1'b1;
          step.bit_val = sh_r[0];
        end else begin
          step.wr      = 1'b1;
          step.bit_val = 1'b0;
        end
        if (step_rdy) begin
          sh_nxt = sh_r << 1;
          if (idx_r == '0) begin
            state_nxt = S_END;
          end else begin
            idx_nxt = idx_r - IDX_W'(1);
          end
        end
      end
      S_END: begin
        step.op = OP_END;
        if (step_rdy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    sh_r   <= sh_nxt;
    idx_r  <= idx_nxt;
    nb_r   <= nb_nxt;
  end

endmodule

`default_nettype wire

[rtl/mbfp_byte_asm.sv]
// Byte assembler: writes single bits into the working byte, keeps the byte
// count and overflow flag, and holds one result back to mark the last one.
// Depends on mbfp_pkg.
`default_nettype none

module mbfp_byte_asm
  import mbfp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  step_t step,
  output logic  step_rdy,
  input  logic  out_free,
  output push_t push
);

  logic [BYTE_BITS-1:0]  work_r, work_nxt;
  logic [BF_W-1:0]       free_r, free_nxt;
  logic [COUNT_BITS-1:0] done_r, done_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  pend_v_r, pend_v_nxt;
  result_t               pend_r, pend_nxt;

  logic [BYTE_BITS-1:0]  cur_byte;
  logic [BYTE_BITS-1:0]  new_byte;
  logic [POS_W-1:0]      pos;
  logic                  bit_w;
  logic                  at_limit;
  logic                  fin_valid;
  logic [COUNT_BITS-1:0] done_inc;
  logic                  fire;

  // A held result can only be replaced once the output register has room.
  assign step_rdy = !pend_v_r || out_free;
  assign fire     = (step.op != OP_NONE) && step_rdy;

  // A new byte starts from the fill byte as it stands when its first bit lands.
  assign cur_byte  = (free_r == BF_W'(BYTE_BITS)) ? cfg.fill_byte : work_r;
  assign pos       = POS_W'(free_r - BF_W'(1));
  assign bit_w     = step.bit_val ^ (step.hl & cfg.pad_code[pos]);
  assign at_limit  = (cfg.length_limit != '0) &&
                     (32'(done_r) >= 32'(cfg.length_limit));
  assign fin_valid = (free_r != BF_W'(BYTE_BITS));
  assign done_inc  = (done_r == '1) ? done_r : done_r + COUNT_BITS'(1);

  always_comb begin
    new_byte      = cur_byte;
    new_byte[pos] = bit_w;
  end

  always_comb begin
    work_nxt   = work_r;
    free_nxt   = free_r;
    done_nxt   = done_r;
    ovf_nxt    = ovf_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    push       = '0;
    if (fire) begin
      unique case (step.op)
        OP_BIT: begin
          if (step.wr && !ovf_r) begin
            if (at_limit) begin
              ovf_nxt = 1'b1;
            end else if (free_r == BF_W'(1)) begin
              done_nxt            = done_inc;
              free_nxt            = BF_W'(BYTE_BITS);
              pend_nxt.data_byte  = new_byte;
              pend_nxt.byte_valid = 1'b1;
              pend_nxt.last       = 1'b0;
              pend_nxt.byte_count = done_inc;
              pend_nxt.overflow   = ovf_r;
              pend_v_nxt          = 1'b1;
              if (pend_v_r) begin
                push.valid = 1'b1;
                push.res   = pend_r;
              end
            end else begin
              work_nxt = new_byte;
              free_nxt = free_r - BF_W'(1);
            end
          end
        end
        OP_FIN: begin
          pend_nxt.data_byte  = fin_valid ? cur_byte : '0;
          pend_nxt.byte_valid = fin_valid;
          pend_nxt.last       = 1'b0;
          pend_nxt.byte_count = fin_valid ? done_inc : done_r;
          pend_nxt.overflow   = ovf_r;
          pend_v_nxt          = 1'b1;
          done_nxt            = '0;
          free_nxt            = BF_W'(BYTE_BITS);
          ovf_nxt             = 1'b0;
        end
        OP_END: begin
          if (pend_v_r) begin
            push.valid    = 1'b1;
            push.res      = pend_r;
            push.res.last = 1'b1;
          end
          pend_v_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r   <= BF_W'(BYTE_BITS);
      done_r   <= '0;
      ovf_r    <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      free_r   <= free_nxt;
      done_r   <= done_nxt;
      ovf_r    <= ovf_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    pend_r <= pend_nxt;
  end

endmodule

`default_nettype wire

[rtl/msb_first_bit_field_packer_hl.sv]
// Channel  | Direction | Contents
// in_      | slave     | tuser: kind; tdata: bit_count, value
// out_     | master    | tuser: byte_valid; tdata: data_byte, byte_count, overflow; tlast
// cfg_     | write     | index 0 length_limit, 1 pad code, 2 fill_byte
//
// One item at a time. After it is accepted, a field walks every bit position of the
// 32-bit value word, a spare run its n bits, an H/L bit or a finish one step; each
// ends with a closing step.
// Reset is synchronous; afterwards the block accepts at once, with no clearing pass.
// A stalled output holds the sequencer whenever a result is held back and the output
// register is still full.
//
// Top level of the MSB-first bit-field packer with H/L coding.
// Depends on mbfp_pkg, mbfp_bit_ser and mbfp_byte_asm.
`default_nettype none

module msb_first_bit_field_packer_hl
  import mbfp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [5:0] bit_count, [37:6] value
  input  logic [1:0]             in_tuser,   // [1:0] kind
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] data_byte, [23:8] byte_count, [24] overflow
  output logic [0:0]             out_tuser,  // [0] byte_valid
  output logic                   out_tlast,
  input  logic                   cfg_we,
  input  cfg_idx_t               cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  cfg_t    cfg_r, cfg_nxt;
  logic    out_v_r, out_v_nxt;
  result_t out_res_r;
  step_t   step;
  logic    step_rdy;
  logic    out_free;
  push_t   push;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_LENGTH_LIMIT: cfg_nxt.length_limit = LIMIT_W'(cfg_wdata);
        CFG_PAD_CODE:     cfg_nxt.pad_code     = cfg_wdata[BYTE_BITS-1:0];
        CFG_FILL_BYTE:    cfg_nxt.fill_byte    = cfg_wdata[BYTE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.length_limit <= '0;
      cfg_r.pad_code     <= PAD_RESET;
      cfg_r.fill_byte    <= PAD_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mbfp_bit_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .kind      (in_tuser),
    .bit_count (in_tdata[CNT_IN_W-1:0]),
    .value     (in_tdata[CNT_IN_W +: FIELD_BITS]),
    .step      (step),
    .step_rdy  (step_rdy)
  );

  mbfp_byte_asm u_asm (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .step     (step),
    .step_rdy (step_rdy),
    .out_free (out_free),
    .push     (push)
  );

  // Output register: a push only comes while it is free or being emptied.
  assign out_free = !out_v_r || out_tready;

  always_comb begin
    out_v_nxt = out_v_r;
    if (push.valid) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      out_res_r <= push.res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_TDATA_W'({out_res_r.overflow, out_res_r.byte_count,
                                    out_res_r.data_byte});
  assign out_tuser  = out_res_r.byte_valid;
  assign out_tlast  = out_res_r.last;

endmodule

`default_nettype wire

[rtl/mbfp_checker.sv]
// Port-level checker of the MSB-first bit-field packer, bound to the top level.
// Depends on mbfp_pkg and the assertion macro header.
`default_nettype none

`include "msb_first_bit_field_packer_hl_assert.svh"

module mbfp_checker
  import mbfp_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [0:0]             out_tuser,
  input logic                   out_tlast
);

  // A stalled result transaction keeps its contents.
  `MBFP_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "result changed while stalled")

  // An empty finish result is always the last one and carries a zero byte.
  `MBFP_ASSERT(a_empty_last, out_tvalid && !out_tuser[0] |-> out_tlast && (out_tdata[7:0] == 8'h00), "empty result not last or not zero")

  // Results ahead of the last are completed bytes written without overflow.
  `MBFP_ASSERT(a_mid_byte, out_tvalid && !out_tlast |-> out_tuser[0] && !out_tdata[24], "bad result ahead of last")

  // The block works on one item at a time.
  `MBFP_ASSERT(a_one_item, in_tvalid && in_tready |=> !in_tready, "input taken while busy")

  // Reset empties the output register.
  `MBFP_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_tvalid, "result present after reset")

endmodule

bind msb_first_bit_field_packer_hl mbfp_checker u_mbfp_checker (.*);

`default_nettype wire
